// File: rtl/slef_pkg.sv
// ============================================================================
// slef_pkg: shared types and constants of the spin lattice effective field
// Holds the controller states, the controller-to-datapath command bundle,
// request codes, register indexes and reset values.
// ============================================================================
`default_nettype none

package slef_pkg;

    // Request kinds carried in the input tuser bit.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Configuration register indexes.
    localparam int  CFG_IDX_W        = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANISOTROPY_K = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCHANGE_J   = 1'b1;

    // Reset values: K is about 0.020 and J is 1.0 in Q4.12, the spin is
    // (1,0,1)/sqrt(2) in Q2.14.
    localparam logic signed [15:0] K_RESET       = 16'sd82;
    localparam logic signed [15:0] J_RESET       = 16'sd4096;
    localparam logic signed [15:0] SPIN_RESET_XZ = 16'sd11585;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEC1,
        ST_DEC2,
        ST_DEC3,
        ST_DEC4,
        ST_READ,
        ST_DRAIN,
        ST_MUL,
        ST_FIN
    } slef_state_t;

    typedef struct packed {
        logic       clear_wr;
        logic       take;
        logic       dec1;
        logic       dec2;
        logic       dec3;
        logic       dec4;
        logic       nb_rd;
        logic [2:0] nb_sel;
        logic       mul;
        logic       load_out;
    } slef_cmd_t;

endpackage

`default_nettype wire

// File: rtl/slef_ctrl.sv
// ============================================================================
// slef_ctrl: sequencing controller
// Runs the clearing pass after reset, accepts requests and steps a query
// through coordinate decode, eight neighbor reads and the field arithmetic.
// ============================================================================
`default_nettype none

module slef_ctrl
    import slef_pkg::*;
#(
    parameter int CELLS_PER_SIDE = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire logic                 in_action,
    input  wire logic                 out_free,
    output logic                      in_ready,
    output slef_cmd_t                 cmd,
    output logic [$clog2(2*CELLS_PER_SIDE**3)-1:0] clr_addr
);

    localparam int SITES = 2 * CELLS_PER_SIDE * CELLS_PER_SIDE * CELLS_PER_SIDE;
    localparam int AW    = $clog2(SITES);
    localparam logic [AW-1:0] LAST_SITE = AW'(SITES - 1);

    slef_state_t   state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [2:0]    rd_cnt_reg, rd_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
        end
    end

    // Next state and counters.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        rd_cnt_next  = rd_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_SITE) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid && in_action == ACT_QUERY) begin
                    state_next = ST_DEC1;
                end
            end
            ST_DEC1: state_next = ST_DEC2;
            ST_DEC2: state_next = ST_DEC3;
            ST_DEC3: state_next = ST_DEC4;
            ST_DEC4: begin
                rd_cnt_next = '0;
                state_next  = ST_READ;
            end
            ST_READ: begin
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg == 3'd7) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_MUL;
            ST_MUL:   state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        clr_addr = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_wr = 1'b1;
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_DEC1:  cmd.dec1 = 1'b1;
            ST_DEC2:  cmd.dec2 = 1'b1;
            ST_DEC3:  cmd.dec3 = 1'b1;
            ST_DEC4:  cmd.dec4 = 1'b1;
            ST_READ: begin
                cmd.nb_rd  = 1'b1;
                cmd.nb_sel = rd_cnt_reg;
            end
            ST_DRAIN: cmd = '0;
            ST_MUL:   cmd.mul = 1'b1;
            ST_FIN:   cmd.load_out = out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/slef_datapath.sv
// ============================================================================
// slef_datapath: spin store and field arithmetic
// Holds the spin memory, the configuration registers, the coordinate
// decoder, the neighbor accumulators, the multipliers and the output register.
// ============================================================================
`default_nettype none

module slef_datapath
    import slef_pkg::*;
#(
    parameter int CELLS_PER_SIDE = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire slef_cmd_t            cmd,
    input  wire logic [$clog2(2*CELLS_PER_SIDE**3)-1:0] clr_addr,
    input  wire logic                 in_action,
    input  wire logic [9:0]           in_site,
    input  wire logic signed [15:0]   in_spin_x,
    input  wire logic signed [15:0]   in_spin_y,
    input  wire logic signed [15:0]   in_spin_z,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [15:0]          cfg_wdata,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      out_free,
    output logic [9:0]                out_site,
    output logic signed [34:0]        out_field_x,
    output logic signed [34:0]        out_field_y,
    output logic signed [34:0]        out_field_z
);

    localparam int N         = CELLS_PER_SIDE;
    localparam int SITES     = 2 * N * N * N;
    localparam int AW        = $clog2(SITES);
    localparam int CW        = $clog2(N);
    localparam int DIV_SHIFT = 16;
    localparam int PW        = DIV_SHIFT + 10;
    // Rounded-up reciprocal of N: exact quotients for dividends below 2^9.
    localparam logic [PW-1:0] RECIP = PW'((2 ** DIV_SHIFT + N - 1) / N);
    localparam logic [8:0]    N9    = 9'(N);
    localparam logic [CW-1:0] NMAX  = CW'(N - 1);
    localparam logic [AW-1:0] X_STEP = AW'(2 * N * N);
    localparam logic [AW-1:0] Y_STEP = AW'(2 * N);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [15:0] anisotropy_k_reg;
    logic signed [15:0] exchange_j_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anisotropy_k_reg <= K_RESET;
            exchange_j_reg   <= J_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ANISOTROPY_K: anisotropy_k_reg <= $signed(cfg_wdata);
                CFG_EXCHANGE_J:   exchange_j_reg   <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Spin memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    logic [47:0]   mem [0:SITES-1];
    logic          in_site_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [47:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [47:0]   rd_data_reg;

    assign in_site_ok = 32'(in_site) < 32'(SITES);
    assign wr_en   = cmd.clear_wr || (cmd.take && in_action == ACT_WRITE && in_site_ok);
    assign wr_addr = cmd.clear_wr ? clr_addr : AW'(in_site);
    assign wr_data = cmd.clear_wr ? {SPIN_RESET_XZ, 16'sd0, SPIN_RESET_XZ}
                                  : {in_spin_z, in_spin_y, in_spin_x};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Query capture and coordinate decode.
    // ------------------------------------------------------------------
    logic [9:0]    site_reg;
    logic          site_ok_reg;
    logic [8:0]    qa_reg, qb_reg;
    logic [CW-1:0] x_reg, y_reg, z_reg;
    logic [PW-1:0] prod_a, prod_b;
    logic [8:0]    cell_idx;
    logic          ttype;
    logic [CW-1:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
    logic [AW-1:0] xb_reg [2];
    logic [AW-1:0] yb_reg [2];
    logic [AW-1:0] zb_reg [2];
    logic [AW-1:0] nb_addr;

    assign cell_idx = site_reg[9:1];
    assign ttype    = site_reg[0];
    assign prod_a   = PW'(cell_idx) * RECIP;
    assign prod_b   = PW'(qa_reg) * RECIP;

    // Type 0 couples at offsets 0 and +1, type 1 at -1 and 0, both wrapping.
    always_comb begin
        if (ttype) begin
            x_lo = (x_reg == '0) ? NMAX : x_reg - CW'(1);
            y_lo = (y_reg == '0) ? NMAX : y_reg - CW'(1);
            z_lo = (z_reg == '0) ? NMAX : z_reg - CW'(1);
            x_hi = x_reg;
            y_hi = y_reg;
            z_hi = z_reg;
        end else begin
            x_lo = x_reg;
            y_lo = y_reg;
            z_lo = z_reg;
            x_hi = (x_reg == NMAX) ? '0 : x_reg + CW'(1);
            y_hi = (y_reg == NMAX) ? '0 : y_reg + CW'(1);
            z_hi = (z_reg == NMAX) ? '0 : z_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            site_reg    <= in_site;
            site_ok_reg <= in_site_ok;
        end
        if (cmd.dec1) begin
            qa_reg <= prod_a[DIV_SHIFT +: 9];
        end
        if (cmd.dec2) begin
            z_reg  <= CW'(cell_idx - 9'(qa_reg * N9));
            qb_reg <= prod_b[DIV_SHIFT +: 9];
        end
        if (cmd.dec3) begin
            y_reg <= CW'(qa_reg - 9'(qb_reg * N9));
            x_reg <= CW'(qb_reg);
        end
        if (cmd.dec4) begin
            xb_reg[0] <= AW'(x_lo) * X_STEP;
            xb_reg[1] <= AW'(x_hi) * X_STEP;
            yb_reg[0] <= AW'(y_lo) * Y_STEP;
            yb_reg[1] <= AW'(y_hi) * Y_STEP;
            zb_reg[0] <= AW'(z_lo) << 1;
            zb_reg[1] <= AW'(z_hi) << 1;
        end
    end

    assign nb_addr = xb_reg[cmd.nb_sel[2]] + yb_reg[cmd.nb_sel[1]]
                   + zb_reg[cmd.nb_sel[0]] + AW'(!ttype);
    assign rd_en   = cmd.dec1 || cmd.nb_rd;
    assign rd_addr = cmd.dec1 ? AW'(site_reg) : nb_addr;

    // ------------------------------------------------------------------
    // Accumulation of the eight neighbor spins and the own z component.
    // ------------------------------------------------------------------
    logic               acc_valid_reg;
    logic signed [18:0] acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [15:0] own_sz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= 1'b0;
        end else begin
            acc_valid_reg <= cmd.nb_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dec1) begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end else if (acc_valid_reg) begin
            acc_x_reg <= acc_x_reg + 19'($signed(rd_data_reg[15:0]));
            acc_y_reg <= acc_y_reg + 19'($signed(rd_data_reg[31:16]));
            acc_z_reg <= acc_z_reg + 19'($signed(rd_data_reg[47:32]));
        end
        if (cmd.dec2) begin
            own_sz_reg <= $signed(rd_data_reg[47:32]);
        end
    end

    // ------------------------------------------------------------------
    // Products and output register.
    // ------------------------------------------------------------------
    logic signed [34:0] jx_reg, jy_reg, jz_reg;
    logic signed [31:0] an_reg;
    logic               out_valid_reg;
    logic [9:0]         out_site_reg;
    logic signed [34:0] out_x_reg, out_y_reg, out_z_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            jx_reg <= 35'(exchange_j_reg) * 35'(acc_x_reg);
            jy_reg <= 35'(exchange_j_reg) * 35'(acc_y_reg);
            jz_reg <= 35'(exchange_j_reg) * 35'(acc_z_reg);
            an_reg <= 32'(anisotropy_k_reg) * 32'(own_sz_reg);
        end
        if (cmd.load_out) begin
            out_site_reg <= site_reg;
            if (site_ok_reg) begin
                out_x_reg <= -jx_reg;
                out_y_reg <= -jy_reg;
                out_z_reg <= (35'(an_reg) <<< 1) - jz_reg;
            end else begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_z_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign out_site    = out_site_reg;
    assign out_field_x = out_x_reg;
    assign out_field_y = out_y_reg;
    assign out_field_z = out_z_reg;

endmodule

`default_nettype wire

// File: rtl/spin_lattice_effective_field.sv
// ============================================================================
// spin_lattice_effective_field: exchange plus anisotropy effective field
// Stores one spin per site of a periodic two-site-per-cell lattice and
// answers field queries for single sites.
// ============================================================================
// The block keeps the Q2.14 spin vector of each of the 2*N^3 sites (N is
// CELLS_PER_SIDE) in a memory with one write port and one registered read
// port. A write request stores one spin as it is accepted and produces no
// result. A query request returns the effective field of a site: minus J
// times the sum of its eight opposite-type neighbors in every component,
// plus 2*K*sz on the z component, all exact at scale 2^-26. A query keeps
// the block from taking requests until it is done: decode steps turn the
// site into cell coordinates, eight reads fetch the neighbors one by one
// through the memory read port, and the drain, multiply and load steps
// finish the sum, multiply and load the result, the load waiting for a free
// output register. Queries for sites beyond the lattice return zero fields;
// writes to them are dropped. After reset, a clearing pass writes the reset
// spin into every site, one site per cycle; requests are held off until it
// finishes, while configuration writes are taken throughout. The result
// register lets the next request in while a result waits on the master side.
// ============================================================================
`default_nettype none

module spin_lattice_effective_field
    import slef_pkg::*;
#(
    parameter int CELLS_PER_SIDE = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Request channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata, low bit first: site[9:0], spin_x[25:10], spin_y[41:26],
    // spin_z[57:42], zero fill [63:58].
    input  wire logic [63:0]          s_tdata,
    // s_tuser: action (0 write spin, 1 query field).
    input  wire logic                 s_tuser,
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata, low bit first: field_site[9:0], field_x[44:10],
    // field_y[79:45], field_z[114:80], zero fill [119:115].
    output logic [119:0]              m_tdata,
    // Configuration write port: 0 anisotropy_k, 1 exchange_j.
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [15:0]          cfg_wdata
);

    localparam int SITES = 2 * CELLS_PER_SIDE * CELLS_PER_SIDE * CELLS_PER_SIDE;
    localparam int AW    = $clog2(SITES);

    slef_cmd_t          cmd;
    logic [AW-1:0]      clr_addr;
    logic               out_free;
    logic [9:0]         field_site;
    logic signed [34:0] field_x, field_y, field_z;

    slef_ctrl #(
        .CELLS_PER_SIDE (CELLS_PER_SIDE)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .out_free  (out_free),
        .in_ready  (s_tready),
        .cmd       (cmd),
        .clr_addr  (clr_addr)
    );

    slef_datapath #(
        .CELLS_PER_SIDE (CELLS_PER_SIDE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .clr_addr    (clr_addr),
        .in_action   (s_tuser),
        .in_site     (s_tdata[9:0]),
        .in_spin_x   ($signed(s_tdata[25:10])),
        .in_spin_y   ($signed(s_tdata[41:26])),
        .in_spin_z   ($signed(s_tdata[57:42])),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_free    (out_free),
        .out_site    (field_site),
        .out_field_x (field_x),
        .out_field_y (field_y),
        .out_field_z (field_z)
    );

    assign m_tdata = {5'd0, field_z, field_y, field_x, field_site};

    // No request is taken while the clearing pass owns the memory.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_wr |-> !s_tready)
        else $error("request accepted during clearing pass");

    // A result is loaded only into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending result");

    // A new result appears only after the controller loaded one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.load_out))
        else $error("result valid without a load");

    // Sites beyond the lattice report zero fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (32'(m_tdata[9:0]) >= 32'(SITES))) |-> (m_tdata[114:10] == '0))
        else $error("nonzero field for a site beyond the lattice");

endmodule

`default_nettype wire

// File: bench/spin_lattice_effective_field_test.sv
// ----------------------------------------------------------------------------
// spin_lattice_effective_field_test: self-checking bench for the field block
// Drives spin writes and field queries with random idle gaps on both stream
// sides, predicts every effective field from its own copy of the lattice
// and the coefficients, and compares each result field by field.
// ----------------------------------------------------------------------------

module spin_lattice_effective_field_test;
    import slef_pkg::*;

    localparam int CELLS       = 8;
    localparam int SITES       = 2 * CELLS * CELLS * CELLS;
    localparam int PHASE_ITEMS = 315;
    localparam int SETTLE      = 24;

    // One expected or observed result, unpacked from m_tdata.
    typedef struct {
        logic [9:0]         site;
        logic signed [34:0] fx;
        logic signed [34:0] fy;
        logic signed [34:0] fz;
    } field_result_t;

    // Tracks the lattice contents and the coefficients as the block sees them,
    // and keeps the fields that queries have asked for but not yet received.
    class spin_field_tracker;
        logic signed [15:0] spin_mem [0:SITES-1][0:2];
        logic signed [15:0] k_coef;
        logic signed [15:0] j_coef;
        field_result_t      pending_fields[$];
        int                 mismatches;
        int                 writes;
        int                 queries;

        function new();
            for (int s = 0; s < SITES; s++) begin
                spin_mem[s][0] = SPIN_RESET_XZ;
                spin_mem[s][1] = '0;
                spin_mem[s][2] = SPIN_RESET_XZ;
            end
            k_coef     = K_RESET;
            j_coef     = J_RESET;
            mismatches = 0;
            writes     = 0;
            queries    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
            if (idx == CFG_ANISOTROPY_K) begin
                k_coef = value;
            end else if (idx == CFG_EXCHANGE_J) begin
                j_coef = value;
            end
        endfunction

        function int wrap_cell(int coord, int delta);
            return (coord + CELLS + delta) % CELLS;
        endfunction

        // Minus J times the eight opposite-type neighbors, plus 2*K*sz on z.
        function field_result_t effective_field(logic [9:0] site);
            field_result_t      r;
            int                 t, cell_idx, cx, cy, cz, lo, nb;
            logic signed [63:0] acc [0:2];
            logic signed [63:0] h [0:2];
            r.site = site;
            for (int c = 0; c < 3; c++) begin
                acc[c] = '0;
                h[c]   = '0;
            end
            if (site < SITES) begin
                t        = site & 1;
                cell_idx = site >> 1;
                cz       = cell_idx % CELLS;
                cy       = (cell_idx / CELLS) % CELLS;
                cx       = cell_idx / (CELLS * CELLS);
                // Type 0 looks forward by 0 or +1 cells, type 1 back by -1 or 0.
                lo   = t ? -1 : 0;
                for (int dx = lo; dx <= lo + 1; dx++)
                    for (int dy = lo; dy <= lo + 1; dy++)
                        for (int dz = lo; dz <= lo + 1; dz++) begin
                            nb = 2 * (CELLS * (CELLS * wrap_cell(cx, dx) + wrap_cell(cy, dy))
                                      + wrap_cell(cz, dz)) + (t ^ 1);
                            for (int c = 0; c < 3; c++)
                                acc[c] += 64'(spin_mem[nb][c]);
                        end
                for (int c = 0; c < 3; c++)
                    h[c] = -64'(j_coef) * acc[c];
                h[2] += 2 * 64'(k_coef) * 64'(spin_mem[site][2]);
            end
            r.fx = h[0][34:0];
            r.fy = h[1][34:0];
            r.fz = h[2][34:0];
            return r;
        endfunction

        function void note_request(logic act, logic [9:0] site, logic [15:0] sx,
                                   logic [15:0] sy, logic [15:0] sz);
            if (act == ACT_WRITE) begin
                if (site < SITES) begin
                    spin_mem[site][0] = sx;
                    spin_mem[site][1] = sy;
                    spin_mem[site][2] = sz;
                end
                writes++;
            end else begin
                pending_fields.insert(pending_fields.size(), effective_field(site));
                queries++;
            end
        endfunction

        function void check_field(logic [119:0] data);
            field_result_t got, want;
            got.site = data[9:0];
            got.fx   = data[44:10];
            got.fy   = data[79:45];
            got.fz   = data[114:80];
            if (pending_fields.size() == 0) begin
                $error("result for site %0d arrived with no query waiting", got.site);
                mismatches++;
                return;
            end
            want = pending_fields.pop_front();
            if (got.site != want.site) begin
                $error("field_site: expected %0d, got %0d", want.site, got.site);
                mismatches++;
            end
            if (got.fx != want.fx) begin
                $error("field_x: expected %0d, got %0d", want.fx, got.fx);
                mismatches++;
            end
            if (got.fy != want.fy) begin
                $error("field_y: expected %0d, got %0d", want.fy, got.fy);
                mismatches++;
            end
            if (got.fz != want.fz) begin
                $error("field_z: expected %0d, got %0d", want.fz, got.fz);
                mismatches++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata, low bit first: site, spin_x, spin_y, spin_z, zero fill.
    logic [63:0]          s_tdata;
    // s_tuser: action.
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // m_tdata, low bit first: field_site, field_x, field_y, field_z, zero fill.
    logic [119:0]         m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [15:0]          cfg_wdata;

    spin_field_tracker    board;

    // When set, neither side inserts idle cycles.
    bit                   steady;

    spin_lattice_effective_field #(
        .CELLS_PER_SIDE(CELLS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Spin components: the range ends, zero and minus one turn up often, the rest is uniform.
    function automatic logic [15:0] spin_value();
        case ($urandom_range(0, 19))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one request and holds it until the block takes it. The valid is
    // left high when no gap follows, so back-to-back requests need no extra step.
    task automatic send_request(input logic act, input logic [9:0] site,
                                input logic [15:0] sx, input logic [15:0] sy,
                                input logic [15:0] sz);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, sz, sy, sx, site};
        do @(posedge aclk); while (!s_tready);
        board.note_request(act, site, sx, sy, sz);
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering requests and waits until every query has been answered,
    // then lets the block finish any trailing write before returning.
    task automatic drain_all();
        s_tvalid <= 1'b0;
        while (board.pending_fields.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_register(idx, value);
        @(posedge aclk);
    endtask

    // A random request. About a third of them hit a small group of sites at
    // the two corners of the lattice, so that writes and queries there meet
    // through the wrap-around neighbors.
    task automatic random_request();
        logic       act;
        logic [9:0] site;
        act = ($urandom_range(0, 1) == 0) ? ACT_WRITE : ACT_QUERY;
        if ($urandom_range(0, 99) < 35)
            site = $urandom_range(0, 1) ? 10'($urandom_range(0, 15))
                                        : 10'($urandom_range(SITES - 16, SITES - 1));
        else
            site = 10'($urandom_range(0, SITES - 1));
        send_request(act, site, spin_value(), spin_value(), spin_value());
    endtask

    // Result side: the ready drops for random stretches unless the run is steady.
    initial begin
        int gap;
        m_tready <= 1'b0;
        repeat (8) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            gap = idle_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Every result taken by the sink is checked against the oldest query.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_field(m_tdata);
    end

    initial begin
        int          phase;
        logic [15:0] k_val;
        logic [15:0] j_val;
        board = new();
        steady = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= ACT_WRITE;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_ANISOTROPY_K;
        cfg_wdata <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, at the reset coefficients. The block holds off the
        // first request until its clearing pass has filled the lattice.
        // Corner sites in the reset lattice: both types at the origin cell and
        // at the far cell, where the neighbor offsets wrap around each axis.
        send_request(ACT_QUERY, 10'd0, '0, '0, '0);
        send_request(ACT_QUERY, 10'd1, '0, '0, '0);
        send_request(ACT_QUERY, 10'(SITES - 2), '0, '0, '0);
        send_request(ACT_QUERY, 10'(SITES - 1), '0, '0, '0);
        // Fill all eight neighbors of site 0 with the most negative x and z.
        for (int n = 0; n < 8; n++)
            send_request(ACT_WRITE, 10'(2 * (64 * n[2] + 8 * n[1] + n[0]) + 1),
                         16'h8000, 16'h7fff, 16'h8000);
        send_request(ACT_WRITE, 10'd0, 16'h7fff, 16'h8000, 16'h8000);
        send_request(ACT_QUERY, 10'd0, '0, '0, '0);
        send_request(ACT_QUERY, 10'd1, '0, '0, '0);
        // The far corner's type 0 site sees site 1 only through the wrap; no far corner site sees site 0.
        send_request(ACT_WRITE, 10'(SITES - 1), 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(ACT_QUERY, 10'(SITES - 2), '0, '0, '0);
        send_request(ACT_QUERY, 10'(SITES - 1), '0, '0, '0);
        send_request(ACT_WRITE, 10'd0, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_QUERY, 10'd0, 16'hffff, 16'hffff, 16'hffff);
        drain_all();

        // Random part, one phase per coefficient setting. Each phase starts
        // and ends with an empty pipeline, so the sender pauses for every
        // outstanding result before the registers change.
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       begin k_val = K_RESET;  j_val = J_RESET;  end
                1:       begin k_val = 16'h7fff; j_val = 16'h8000; end
                2:       begin k_val = 16'h8000; j_val = 16'h7fff; end
                3:       begin k_val = 16'h0000; j_val = 16'h0000; end
                4:       begin k_val = 16'hffff; j_val = 16'h0001; end
                default: begin k_val = 16'($urandom); j_val = 16'($urandom); end
            endcase
            write_register(CFG_ANISOTROPY_K, k_val);
            write_register(CFG_EXCHANGE_J, j_val);
            // One phase runs with no idle cycles at all on either side.
            steady = (phase == 2);
            send_request(ACT_QUERY, 10'd0, '0, '0, '0);
            send_request(ACT_QUERY, 10'(SITES - 1), '0, '0, '0);
            repeat (PHASE_ITEMS) random_request();
            drain_all();
        end

        $display("Run covered %0d spin writes and %0d field queries", board.writes,
                 board.queries);
        $display("over the reset, extreme, zero and random coefficient settings.");
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, clearing pass included.
    initial begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
